// ----- sv/union_find_path_compression_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the union-find unit
// Concurrent assertion helpers clocked on clk_i and disabled during rst_ni.
// ----------------------------------------------------------------------------
`ifndef UNION_FIND_PATH_COMPRESSION_UNIT_DEFINES_SVH
`define UNION_FIND_PATH_COMPRESSION_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Condition that must hold whenever the block is out of reset.
`define UFPC_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("union-find unit: assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define UFPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("union-find unit: assertion failed");

`else

`define UFPC_ASSERT(lbl, cond)
`define UFPC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- sv/ufpc_pkg.sv -----
// ----------------------------------------------------------------------------
// Union-find package
// Table sizes and the structs passed between the sequencer and the top level.
// ----------------------------------------------------------------------------
package ufpc_pkg;

  // Element index width; every index of that width is a table entry.
  localparam int IDX_W    = 10;
  localparam int ELEMENTS = 1 << IDX_W;
  // A set can hold every element, so one more bit than the index.
  localparam int SIZE_W   = IDX_W + 1;

  // Access to the parent-link table.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } ufpc_par_req_t;

  // Access to the set-size table.
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [SIZE_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } ufpc_size_req_t;

  // Finished result offered by the sequencer.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] root;
    logic             merged;
  } ufpc_res_t;

endpackage

// ----- sv/union_find_path_compression_unit.sv -----
// ----------------------------------------------------------------------------
// Union-find unit with union by size and full path compression
// Disjoint-set table over 1024 elements answering find and union requests.
// ----------------------------------------------------------------------------
// After reset the unit clears all 1024 entries of its tables and takes no
// item meanwhile. It then works on one item at a time. The chain walk makes
// one access to the parent-link memory a cycle, and the registered read of
// that memory sets its pace. A find walks up from its element to the root,
// then rewrites each link on the path to point at the root, and then
// finishes; a find of a root skips the rewrite. A union walks both elements
// in the same way, with a closing step after each walk, and when the roots
// differ it goes on to compare sizes and link the roots. The result sits in
// an output register, so a new item can be taken while it waits.
module union_find_path_compression_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        req_type_i,
  input  logic [ufpc_pkg::IDX_W-1:0]  elem_a_i,
  input  logic [ufpc_pkg::IDX_W-1:0]  elem_b_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ufpc_pkg::IDX_W-1:0]  root_out_o,
  output logic                        merged_o
);

  ufpc_pkg::ufpc_par_req_t            par_req;
  ufpc_pkg::ufpc_size_req_t           size_req;
  ufpc_pkg::ufpc_res_t                res;
  logic [ufpc_pkg::IDX_W-1:0]         par_rdata;
  logic [ufpc_pkg::SIZE_W-1:0]        size_rdata;
  logic                               res_ready;
  logic                               out_valid_q;
  logic [ufpc_pkg::IDX_W-1:0]         root_out_q;
  logic                               merged_q;

  ufpc_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .elem_a_i     (elem_a_i),
    .elem_b_i     (elem_b_i),
    .par_req_o    (par_req),
    .par_rdata_i  (par_rdata),
    .size_req_o   (size_req),
    .size_rdata_i (size_rdata),
    .res_o        (res),
    .res_ready_i  (res_ready)
  );

  // Parent-link table.
  ufpc_ram #(
    .DEPTH (ufpc_pkg::ELEMENTS),
    .WIDTH (ufpc_pkg::IDX_W)
  ) u_par_ram (
    .clk_i   (clk_i),
    .we_i    (par_req.we),
    .waddr_i (par_req.waddr),
    .wdata_i (par_req.wdata),
    .raddr_i (par_req.raddr),
    .rdata_o (par_rdata)
  );

  // Set-size table.
  ufpc_ram #(
    .DEPTH (ufpc_pkg::ELEMENTS),
    .WIDTH (ufpc_pkg::SIZE_W)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (size_req.we),
    .waddr_i (size_req.waddr),
    .wdata_i (size_req.wdata),
    .raddr_i (size_req.raddr),
    .rdata_o (size_rdata)
  );

  // The output register takes a result when it is empty or being emptied.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      root_out_q <= res.root;
      merged_q   <= res.merged;
    end
  end

  assign out_valid_o = out_valid_q;
  assign root_out_o  = root_out_q;
  assign merged_o    = merged_q;

endmodule

// ----- sv/ufpc_ram.sv -----
// ----------------------------------------------------------------------------
// Union-find table memory
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module ufpc_ram #(
  parameter  int DEPTH = 1024,
  parameter  int WIDTH = 10,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, and read the old contents of the addressed entry.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/ufpc_seq.sv -----
// ----------------------------------------------------------------------------
// Union-find sequencer
// Walks parent chains, compresses them and merges sets, with at most one write
// and one read on each table a cycle, and clears both tables after reset.
// ----------------------------------------------------------------------------
`include "union_find_path_compression_unit_defines.svh"

module ufpc_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         req_type_i,
  input  logic [ufpc_pkg::IDX_W-1:0]   elem_a_i,
  input  logic [ufpc_pkg::IDX_W-1:0]   elem_b_i,
  output ufpc_pkg::ufpc_par_req_t      par_req_o,
  input  logic [ufpc_pkg::IDX_W-1:0]   par_rdata_i,
  output ufpc_pkg::ufpc_size_req_t     size_req_o,
  input  logic [ufpc_pkg::SIZE_W-1:0]  size_rdata_i,
  output ufpc_pkg::ufpc_res_t          res_o,
  input  logic                         res_ready_i
);

  localparam int IW = ufpc_pkg::IDX_W;
  localparam int SW = ufpc_pkg::SIZE_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_CWALK = 3'd3;
  localparam logic [2:0] S_FEND  = 3'd4;
  localparam logic [2:0] S_SZB   = 3'd5;
  localparam logic [2:0] S_MERGE = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]    state_q, state_d;
  logic [IW-1:0] clr_q, clr_d;
  logic [IW-1:0] cur_q, cur_d;
  logic [IW-1:0] start_q, start_d;
  logic [IW-1:0] root_q, root_d;
  logic [IW-1:0] ra_q, ra_d;
  logic [SW-1:0] sa_q, sa_d;
  logic          op_b_q, op_b_d;
  logic          req_type_q, req_type_d;
  logic [IW-1:0] elem_b_q, elem_b_d;
  logic [IW-1:0] res_root_q, res_root_d;
  logic          res_merged_q, res_merged_d;
  logic [SW-1:0] size_sum;

  // Sizes never exceed the element count, so the sum fits.
  assign size_sum = sa_q + size_rdata_i;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    start_q      <= start_d;
    root_q       <= root_d;
    ra_q         <= ra_d;
    sa_q         <= sa_d;
    op_b_q       <= op_b_d;
    req_type_q   <= req_type_d;
    elem_b_q     <= elem_b_d;
    res_root_q   <= res_root_d;
    res_merged_q <= res_merged_d;
  end

  // Sequencer: at most one write and one read on each table per cycle.
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    cur_d        = cur_q;
    start_d      = start_q;
    root_d       = root_q;
    ra_d         = ra_q;
    sa_d         = sa_q;
    op_b_d       = op_b_q;
    req_type_d   = req_type_q;
    elem_b_d     = elem_b_q;
    res_root_d   = res_root_q;
    res_merged_d = res_merged_q;
    in_ready_o   = 1'b0;
    par_req_o    = '0;
    size_req_o   = '0;

    unique case (state_q)
      S_CLEAR: begin
        // Every entry becomes its own root of a set of one.
        par_req_o.we     = 1'b1;
        par_req_o.waddr  = clr_q;
        par_req_o.wdata  = clr_q;
        size_req_o.we    = 1'b1;
        size_req_o.waddr = clr_q;
        size_req_o.wdata = SW'(1);
        clr_d            = clr_q + IW'(1);
        if (clr_q == IW'(ufpc_pkg::ELEMENTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_type_d      = req_type_i;
          elem_b_d        = elem_b_i;
          cur_d           = elem_a_i;
          start_d         = elem_a_i;
          op_b_d          = 1'b0;
          par_req_o.raddr = elem_a_i;
          state_d         = S_WALK;
        end
      end
      S_WALK: begin
        // Read data is the parent of the current entry.
        if (par_rdata_i == cur_q) begin
          root_d = cur_q;
          if (cur_q == start_q) begin
            state_d = S_FEND;
          end else begin
            cur_d           = start_q;
            par_req_o.raddr = start_q;
            state_d         = S_CWALK;
          end
        end else begin
          cur_d           = par_rdata_i;
          par_req_o.raddr = par_rdata_i;
        end
      end
      S_CWALK: begin
        // Point the current entry at the root and move to its old parent.
        par_req_o.we    = 1'b1;
        par_req_o.waddr = cur_q;
        par_req_o.wdata = root_q;
        if (par_rdata_i == root_q) begin
          state_d = S_FEND;
        end else begin
          cur_d           = par_rdata_i;
          par_req_o.raddr = par_rdata_i;
        end
      end
      S_FEND: begin
        if (!op_b_q) begin
          if (req_type_q) begin
            // Union: go on to the second element.
            ra_d            = root_q;
            op_b_d          = 1'b1;
            cur_d           = elem_b_q;
            start_d         = elem_b_q;
            par_req_o.raddr = elem_b_q;
            state_d         = S_WALK;
          end else begin
            res_root_d   = root_q;
            res_merged_d = 1'b0;
            state_d      = S_DONE;
          end
        end else if (ra_q == root_q) begin
          res_root_d   = ra_q;
          res_merged_d = 1'b0;
          state_d      = S_DONE;
        end else begin
          size_req_o.raddr = ra_q;
          state_d          = S_SZB;
        end
      end
      S_SZB: begin
        sa_d             = size_rdata_i;
        size_req_o.raddr = root_q;
        state_d          = S_MERGE;
      end
      S_MERGE: begin
        // Smaller set goes under the larger; ties keep the first root.
        par_req_o.we     = 1'b1;
        size_req_o.we    = 1'b1;
        size_req_o.wdata = size_sum;
        if (sa_q < size_rdata_i) begin
          par_req_o.waddr  = ra_q;
          par_req_o.wdata  = root_q;
          size_req_o.waddr = root_q;
          res_root_d       = root_q;
        end else begin
          par_req_o.waddr  = root_q;
          par_req_o.wdata  = ra_q;
          size_req_o.waddr = ra_q;
          res_root_d       = ra_q;
        end
        res_merged_d = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  assign res_o.valid  = (state_q == S_DONE);
  assign res_o.root   = res_root_q;
  assign res_o.merged = res_merged_q;

  // An accepted item starts with a walk.
  `UFPC_ASSERT_NEXT(a_accept_walks, in_valid_i && in_ready_o, state_q == S_WALK)
  // Only a union can report a merge.
  `UFPC_ASSERT(a_merge_union, res_o.valid && res_o.merged |-> req_type_q)
  // Outside the clearing pass no entry is ever linked to itself.
  `UFPC_ASSERT(a_no_self_link,
               par_req_o.we && state_q != S_CLEAR |-> par_req_o.waddr != par_req_o.wdata)
  // Sizes change only when clearing or merging.
  `UFPC_ASSERT(a_size_write,
               size_req_o.we |-> state_q == S_CLEAR || state_q == S_MERGE)

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// Testbench for the union-find unit
// Drives find and union items through the valid/ready input channel, keeps
// its own copy of the parent-link and set-size tables to work out each
// expected root and merge flag, and checks every result item in order.
// Both channels idle at random, the receiver stalls for a long stretch once,
// and the table is grown into deep trees so that path compression matters.
// ----------------------------------------------------------------------------
module tb_top;

  // Table dimensions taken from the package.
  localparam int IDX_W    = ufpc_pkg::IDX_W;
  localparam int SIZE_W   = ufpc_pkg::SIZE_W;
  localparam int ELEMENTS = ufpc_pkg::ELEMENTS;

  // Request codes carried on req_type_i.
  localparam logic REQ_FIND  = 1'b0;
  localparam logic REQ_UNION = 1'b1;

  localparam int IDLE_PERCENT   = 31;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 60;
  localparam int TIMEOUT_CYCLES = 2_000_000;

  typedef struct {
    logic [IDX_W-1:0] root;
    logic             merged;
  } uf_result_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  logic             req_type_i  = REQ_FIND;
  logic [IDX_W-1:0] elem_a_i    = '0;
  logic [IDX_W-1:0] elem_b_i    = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [IDX_W-1:0] root_out_o;
  logic             merged_o;

  // Shadow copy of the disjoint-set tables.
  logic [IDX_W-1:0]  parent_shadow [ELEMENTS];
  logic [SIZE_W-1:0] size_shadow   [ELEMENTS];

  uf_result_t expected_results[$];

  int  n_errors     = 0;
  int  n_finds      = 0;
  int  n_unions     = 0;
  int  n_merges     = 0;
  int  deepest_walk = 0;
  bit  calm         = 1'b0;
  bit  offering     = 1'b0;
  int  hold_req     = 0;
  int  hold_left    = 0;

  union_find_path_compression_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .elem_a_i    (elem_a_i),
    .elem_b_i    (elem_b_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .root_out_o  (root_out_o),
    .merged_o    (merged_o)
  );

  // Free-running clock.
  always #5 clk_i = ~clk_i;

  // Root of x, rewriting every link on the way so it points at the root.
  function automatic logic [IDX_W-1:0] root_with_compression(input logic [IDX_W-1:0] x);
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] cur;
    logic [IDX_W-1:0] nxt;
    int               steps;
    r     = x;
    steps = 0;
    while (parent_shadow[r] != r && steps < ELEMENTS) begin
      r = parent_shadow[r];
      steps++;
    end
    if (steps > deepest_walk) deepest_walk = steps;
    cur   = x;
    steps = 0;
    while (cur != r && steps < ELEMENTS) begin
      nxt                = parent_shadow[cur];
      parent_shadow[cur] = r;
      cur                = nxt;
      steps++;
    end
    return r;
  endfunction

  // Apply one accepted item to the shadow tables and queue its result.
  // Every 10-bit index is a table entry here, so both indices are always
  // valid.
  function automatic void apply_request(input logic rt, input logic [IDX_W-1:0] a,
                                        input logic [IDX_W-1:0] b);
    uf_result_t       res;
    logic [IDX_W-1:0] ra;
    logic [IDX_W-1:0] rb;
    res.root   = a;
    res.merged = 1'b0;
    if (rt == REQ_FIND) begin
      n_finds++;
      res.root = root_with_compression(a);
    end else begin
      n_unions++;
      ra       = root_with_compression(a);
      rb       = root_with_compression(b);
      res.root = ra;
      if (ra != rb) begin
        if (size_shadow[ra] < size_shadow[rb]) begin
          parent_shadow[ra] = rb;
          size_shadow[rb]   = size_shadow[rb] + size_shadow[ra];
          res.root          = rb;
        end else begin
          parent_shadow[rb] = ra;
          size_shadow[ra]   = size_shadow[ra] + size_shadow[rb];
        end
        res.merged = 1'b1;
        n_merges++;
      end
    end
    expected_results.insert(expected_results.size(), res);
  endfunction

  function automatic logic [IDX_W-1:0] rand_elem();
    return IDX_W'($urandom_range(0, ELEMENTS - 1));
  endfunction

  // Offer one item and wait until the block takes it. Valid is only lowered
  // when a gap precedes the item, so back-to-back items keep it high.
  task automatic send_item(input logic rt, input logic [IDX_W-1:0] a,
                           input logic [IDX_W-1:0] b);
    int gap;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PERCENT) gap++;
    end
    if (gap > 0 && offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
    repeat (gap) @(posedge clk_i);
    in_valid_i <= 1'b1;
    req_type_i <= rt;
    elem_a_i   <= a;
    elem_b_i   <= b;
    offering = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    apply_request(rt, a, b);
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random ready, a counted hold-off on request, or always ready.
  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (calm) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // Compare each result item with the oldest expectation.
  always @(posedge clk_i) begin : check_result
    uf_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result item with nothing expected: root_out=%0d merged=%0b",
               root_out_o, merged_o);
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        if (root_out_o !== want.root) begin
          $error("root_out mismatch: expected %0d, actual %0d", want.root, root_out_o);
          n_errors++;
        end
        if (merged_o !== want.merged) begin
          $error("merged mismatch: expected %0b, actual %0b", want.merged, merged_o);
          n_errors++;
        end
      end
    end
  end

  // Lone elements at the index extremes, a self-union and a same-set union.
  task automatic test_extremes();
    send_item(REQ_FIND, 10'd0, 10'd1023);
    send_item(REQ_FIND, 10'd1023, 10'd0);
    send_item(REQ_FIND, 10'd512, 10'd511);
    send_item(REQ_UNION, 10'd5, 10'd5);
    send_item(REQ_UNION, 10'd0, 10'd1023);
    send_item(REQ_UNION, 10'd1023, 10'd0);
    send_item(REQ_FIND, 10'd1023, rand_elem());
    drain();
  endtask

  // A binomial tree over eight elements gives a three-link path to compress,
  // then a smaller set is merged under it.
  task automatic test_deep_path();
    send_item(REQ_UNION, 10'd16, 10'd17);
    send_item(REQ_UNION, 10'd18, 10'd19);
    send_item(REQ_UNION, 10'd20, 10'd21);
    send_item(REQ_UNION, 10'd22, 10'd23);
    send_item(REQ_UNION, 10'd16, 10'd18);
    send_item(REQ_UNION, 10'd20, 10'd22);
    send_item(REQ_UNION, 10'd16, 10'd20);
    send_item(REQ_FIND, 10'd23, rand_elem());
    send_item(REQ_FIND, 10'd23, rand_elem());
    send_item(REQ_UNION, 10'd0, 10'd23);
    send_item(REQ_UNION, 10'd21, 10'd1023);
    drain();
  endtask

  // Blocks of fresh elements are merged level by level through random
  // members, so trees grow deep before finds flatten them.
  task automatic test_random_trees();
    int base;
    int prev;
    int span;
    int s;
    int i;
    int lo;
    int hi;
    base = 64;
    prev = -1;
    while (base + 32 <= 640) begin
      span = 1 << $urandom_range(3, 5);
      for (s = 1; s < span; s = s * 2) begin
        for (i = 0; i < span; i = i + 2 * s) begin
          lo = base + i + $urandom_range(0, s - 1);
          hi = base + i + s + $urandom_range(0, s - 1);
          if ($urandom_range(0, 1)) send_item(REQ_UNION, IDX_W'(lo), IDX_W'(hi));
          else                      send_item(REQ_UNION, IDX_W'(hi), IDX_W'(lo));
        end
      end
      repeat (span / 2) begin
        send_item(REQ_FIND, IDX_W'(base + $urandom_range(0, span - 1)), rand_elem());
      end
      // Both elements already share a root.
      send_item(REQ_UNION, IDX_W'(base + $urandom_range(0, span - 1)),
                IDX_W'(base + $urandom_range(0, span - 1)));
      if (prev >= 0 && $urandom_range(0, 1)) begin
        send_item(REQ_UNION, IDX_W'(base + $urandom_range(0, span - 1)),
                  IDX_W'(prev + $urandom_range(0, 7)));
      end
      if ($urandom_range(0, 3) == 0) begin
        send_item(logic'($urandom_range(0, 1)), rand_elem(), rand_elem());
      end
      prev = base;
      base = base + span;
    end
    drain();
  endtask

  // The receiver holds off while items keep coming, so the input stalls;
  // then the sender waits for every result before going on.
  task automatic test_backpressure();
    hold_req = HOLD_CYCLES;
    repeat (24) send_item(logic'($urandom_range(0, 1)), rand_elem(), rand_elem());
    drain();
  endtask

  // Mixed traffic over the whole table with a stretch of no idling.
  task automatic test_random_mix();
    int n;
    int pick;
    logic [IDX_W-1:0] a;
    for (n = 0; n < 550; n++) begin
      calm = (n >= 150 && n < 350);
      pick = $urandom_range(0, 99);
      a    = rand_elem();
      if (pick < 40) begin
        send_item(REQ_FIND, a, rand_elem());
      end else if (pick < 75) begin
        send_item(REQ_UNION, a, rand_elem());
      end else if (pick < 85) begin
        send_item(REQ_UNION, a, a);
      end else begin
        // Small hot window at the top of the table, often the same set.
        send_item(REQ_UNION, IDX_W'(960 + $urandom_range(0, 63)),
                  IDX_W'(960 + $urandom_range(0, 63)));
      end
    end
    calm = 1'b0;
    drain();
  endtask

  // Main sequence.
  initial begin
    for (int k = 0; k < ELEMENTS; k++) begin
      parent_shadow[k] = IDX_W'(k);
      size_shadow[k]   = SIZE_W'(1);
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_extremes();
    test_deep_path();
    test_random_trees();
    test_backpressure();
    test_random_mix();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected result items never arrived", expected_results.size());
      n_errors++;
    end
    $display("Covered %0d finds and %0d unions (%0d merging); deepest walk %0d links.",
             n_finds, n_unions, n_merges, deepest_walk);
    $display("Included a %0d-cycle receiver hold-off and a no-idle stretch.", HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- union_find_path_compression_unit.f -----
+incdir+sv
sv/ufpc_pkg.sv
sv/ufpc_ram.sv
sv/ufpc_seq.sv
sv/union_find_path_compression_unit.sv
dv/tb_top.sv
